>>> rtl/sbct_pkg.sv
// Package for the swept box collision time block.
// Holds the default widths and the flag bundle that travels beside the dividers.
`timescale 1ns / 1ps
package sbct_pkg;

    localparam int unsigned TimeFracBitsDefault = 16;
    localparam int unsigned CoordBitsDefault    = 16;

    typedef struct packed {
        logic valid;
        logic miss;
        logic ent_x;
        logic ext_x;
        logic ent_y;
        logic ext_y;
    } t_side;

endpackage

>>> rtl/sbct_axis.sv
// Front stage for one axis: edge sums, early rejects and the distances to divide.
// Uses sbct_pkg.
`timescale 1ns / 1ps
module sbct_axis
    import sbct_pkg::*;
#(
    parameter int unsigned COORD_BITS = CoordBitsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_m,
    input  logic        [COORD_BITS-2:0] i_msz,
    input  logic signed [COORD_BITS-1:0] i_t,
    input  logic        [COORD_BITS-2:0] i_tsz,
    input  logic signed [COORD_BITS-1:0] i_s,
    output logic                         o_reject,
    output logic                         o_ent_v,
    output logic        [COORD_BITS:0]   o_ent_d,
    output logic                         o_ext_v,
    output logic        [COORD_BITS:0]   o_ext_d,
    output logic        [COORD_BITS-1:0] o_mag
);

    localparam int unsigned W = COORD_BITS + 2;

    logic signed [W-1:0] m, t, mr, tr, s;
    logic signed [W-1:0] d_ent, d_ext;
    logic n_reject, n_ent_v, n_ext_v;
    logic [COORD_BITS-1:0] n_mag;
    logic r_reject, r_ent_v, r_ext_v;
    logic [COORD_BITS:0] r_ent_d, r_ext_d;
    logic [COORD_BITS-1:0] r_mag;

    always_comb begin
        m  = W'(i_m);
        t  = W'(i_t);
        s  = W'(i_s);
        mr = m + $signed({2'b00, i_msz});
        tr = t + $signed({2'b00, i_tsz});
        n_reject = 1'b0;
        n_ent_v  = 1'b0;
        n_ext_v  = 1'b0;
        d_ent    = '0;
        d_ext    = '0;
        n_mag    = COORD_BITS'(1);
        if (s < 0) begin
            n_reject = (mr <= t);
            n_ent_v  = (tr < m);
            d_ent    = m - tr;
            n_ext_v  = 1'b1;
            d_ext    = mr - t;
            n_mag    = COORD_BITS'(-s);
        end else if (s > 0) begin
            n_reject = (m >= tr);
            n_ent_v  = (mr < t);
            d_ent    = t - mr;
            n_ext_v  = (tr > m);
            d_ext    = tr - m;
            n_mag    = COORD_BITS'(s);
        end else begin
            n_reject = !((mr > t) && (m < tr));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_reject <= n_reject;
            r_ent_v  <= n_ent_v;
            r_ext_v  <= n_ext_v;
            r_ent_d  <= d_ent[COORD_BITS:0];
            r_ext_d  <= d_ext[COORD_BITS:0];
            r_mag    <= n_mag;
        end
    end

    assign o_reject = r_reject;
    assign o_ent_v  = r_ent_v;
    assign o_ent_d  = r_ent_d;
    assign o_ext_v  = r_ext_v;
    assign o_ext_d  = r_ext_d;
    assign o_mag    = r_mag;

endmodule

>>> rtl/sbct_divider.sv
// Pipelined restoring divider, one quotient bit per stage, saturating at 2.0 and above.
// Uses sbct_pkg for default widths.
`timescale 1ns / 1ps
module sbct_divider
    import sbct_pkg::*;
#(
    parameter int unsigned TIME_FRAC_BITS = TimeFracBitsDefault,
    parameter int unsigned COORD_BITS     = CoordBitsDefault
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [COORD_BITS:0]       i_dividend,
    input  logic [COORD_BITS-1:0]     i_divisor,
    output logic [TIME_FRAC_BITS:0]   o_quotient
);

    localparam int unsigned Q  = TIME_FRAC_BITS + 1;
    localparam int unsigned RW = COORD_BITS + 1;
    localparam int unsigned XW = COORD_BITS + 2;

    logic [RW-1:0]         r_rem [Q];
    logic [Q-1:0]          r_quo [Q];
    logic [COORD_BITS-1:0] r_div [Q];
    logic                  r_sat [Q];

    genvar j;
    generate
        for (j = 0; j < Q; j++) begin : g_stage
            logic [XW-1:0]         x;
            logic [COORD_BITS-1:0] dv;
            logic [Q-1:0]          qin;
            logic                  sin;
            logic [XW-1:0]         diff;
            logic                  bit_q;
            logic [RW-1:0]         n_rem;
            logic [Q-1:0]          n_quo;
            logic                  n_sat;

            if (j == 0) begin : g_first
                assign x   = {1'b0, i_dividend};
                assign dv  = i_divisor;
                assign qin = '0;
                assign sin = ({1'b0, i_dividend} >= {1'b0, i_divisor, 1'b0});
            end else begin : g_next
                assign x   = {r_rem[j-1], 1'b0};
                assign dv  = r_div[j-1];
                assign qin = r_quo[j-1];
                assign sin = r_sat[j-1];
            end

            always_comb begin
                diff  = x - {2'b00, dv};
                bit_q = (x >= {2'b00, dv});
                n_rem = bit_q ? diff[RW-1:0] : x[RW-1:0];
                n_quo = qin;
                n_quo[Q-1-j] = bit_q;
                n_sat = sin;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= n_rem;
                    r_quo[j] <= n_quo;
                    r_div[j] <= dv;
                    r_sat[j] <= n_sat;
                end
            end
        end
    endgenerate

    assign o_quotient = r_sat[Q-1] ? {Q{1'b1}} : r_quo[Q-1];

endmodule

>>> rtl/sbct_resolve.sv
// Output stage: merges the axis time bounds into hit and entry time.
// Uses sbct_pkg for the flag bundle.
`timescale 1ns / 1ps
module sbct_resolve
    import sbct_pkg::*;
#(
    parameter int unsigned TIME_FRAC_BITS = TimeFracBitsDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_side                   i_side,
    input  logic [TIME_FRAC_BITS:0] i_ent_x,
    input  logic [TIME_FRAC_BITS:0] i_ext_x,
    input  logic [TIME_FRAC_BITS:0] i_ent_y,
    input  logic [TIME_FRAC_BITS:0] i_ext_y,
    output logic                    o_valid,
    output logic                    o_hit,
    output logic [TIME_FRAC_BITS:0] o_entry_time
);

    localparam logic [TIME_FRAC_BITS:0] One = {1'b1, {TIME_FRAC_BITS{1'b0}}};

    logic [TIME_FRAC_BITS:0] ent_a, ent_b, ent_m, ext_a, ext_b, ext_m;
    logic                    n_hit;
    logic [TIME_FRAC_BITS:0] n_time;
    logic                    r_valid, r_hit;
    logic [TIME_FRAC_BITS:0] r_time;

    always_comb begin
        ent_a  = i_side.ent_x ? i_ent_x : '0;
        ent_b  = i_side.ent_y ? i_ent_y : '0;
        ent_m  = (ent_a > ent_b) ? ent_a : ent_b;
        ext_a  = (i_side.ext_x && (i_ext_x < One)) ? i_ext_x : One;
        ext_b  = (i_side.ext_y && (i_ext_y < ext_a)) ? i_ext_y : ext_a;
        ext_m  = ext_b;
        n_hit  = !i_side.miss && (ent_m <= ext_m);
        n_time = n_hit ? ent_m : One;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit  <= n_hit;
            r_time <= n_time;
        end
    end

    assign o_valid      = r_valid;
    assign o_hit        = r_hit;
    assign o_entry_time = r_time;

endmodule

>>> rtl/swept_box_collision_time.sv
// Swept box collision time: one box pair per cycle while the pipeline is not stalled.
// The pipeline is one front stage, one divider stage per quotient bit (TIME_FRAC_BITS + 1)
// and one output register. The whole pipeline advances together and holds while the
// output word is stalled, so a new word is taken in every cycle in which o_stall is low.
// Uses sbct_pkg, sbct_axis, sbct_divider and sbct_resolve.
`timescale 1ns / 1ps
module swept_box_collision_time
    import sbct_pkg::*;
#(
    parameter int unsigned TIME_FRAC_BITS = TimeFracBitsDefault,
    parameter int unsigned COORD_BITS     = CoordBitsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_mover_x,
    input  logic signed [COORD_BITS-1:0] i_mover_y,
    input  logic        [COORD_BITS-2:0] i_mover_w,
    input  logic        [COORD_BITS-2:0] i_mover_h,
    input  logic signed [COORD_BITS-1:0] i_target_x,
    input  logic signed [COORD_BITS-1:0] i_target_y,
    input  logic        [COORD_BITS-2:0] i_target_w,
    input  logic        [COORD_BITS-2:0] i_target_h,
    input  logic signed [COORD_BITS-1:0] i_speed_x,
    input  logic signed [COORD_BITS-1:0] i_speed_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic        [TIME_FRAC_BITS:0] o_entry_time
);

    localparam int unsigned Lat = TIME_FRAC_BITS + 1;

    logic en;
    logic rej_x, rej_y, env_x, env_y, exv_x, exv_y;
    logic [COORD_BITS:0] end_x, exd_x, end_y, exd_y;
    logic [COORD_BITS-1:0] mag_x, mag_y;
    logic [TIME_FRAC_BITS:0] q_ent_x, q_ext_x, q_ent_y, q_ext_y;
    logic r_front_valid;
    t_side n_side;
    t_side r_side [Lat];

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    sbct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .i_clk(i_clk), .i_en(en),
        .i_m(i_mover_x), .i_msz(i_mover_w), .i_t(i_target_x), .i_tsz(i_target_w),
        .i_s(i_speed_x),
        .o_reject(rej_x), .o_ent_v(env_x), .o_ent_d(end_x),
        .o_ext_v(exv_x), .o_ext_d(exd_x), .o_mag(mag_x)
    );

    sbct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .i_clk(i_clk), .i_en(en),
        .i_m(i_mover_y), .i_msz(i_mover_h), .i_t(i_target_y), .i_tsz(i_target_h),
        .i_s(i_speed_y),
        .o_reject(rej_y), .o_ent_v(env_y), .o_ent_d(end_y),
        .o_ext_v(exv_y), .o_ext_d(exd_y), .o_mag(mag_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (en) begin
            r_front_valid <= i_valid;
        end
    end

    sbct_divider #(.TIME_FRAC_BITS(TIME_FRAC_BITS), .COORD_BITS(COORD_BITS)) u_div_ent_x (
        .i_clk(i_clk), .i_en(en), .i_dividend(end_x), .i_divisor(mag_x),
        .o_quotient(q_ent_x)
    );

    sbct_divider #(.TIME_FRAC_BITS(TIME_FRAC_BITS), .COORD_BITS(COORD_BITS)) u_div_ext_x (
        .i_clk(i_clk), .i_en(en), .i_dividend(exd_x), .i_divisor(mag_x),
        .o_quotient(q_ext_x)
    );

    sbct_divider #(.TIME_FRAC_BITS(TIME_FRAC_BITS), .COORD_BITS(COORD_BITS)) u_div_ent_y (
        .i_clk(i_clk), .i_en(en), .i_dividend(end_y), .i_divisor(mag_y),
        .o_quotient(q_ent_y)
    );

    sbct_divider #(.TIME_FRAC_BITS(TIME_FRAC_BITS), .COORD_BITS(COORD_BITS)) u_div_ext_y (
        .i_clk(i_clk), .i_en(en), .i_dividend(exd_y), .i_divisor(mag_y),
        .o_quotient(q_ext_y)
    );

    always_comb begin
        n_side.valid = r_front_valid;
        n_side.miss  = rej_x || rej_y;
        n_side.ent_x = env_x;
        n_side.ext_x = exv_x;
        n_side.ent_y = env_y;
        n_side.ext_y = exv_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Lat; k++) begin
                r_side[k] <= '0;
            end
        end else if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < Lat; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    sbct_resolve #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_resolve (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_side(r_side[Lat-1]),
        .i_ent_x(q_ent_x), .i_ext_x(q_ext_x), .i_ent_y(q_ent_y), .i_ext_y(q_ext_y),
        .o_valid(o_valid), .o_hit(o_hit), .o_entry_time(o_entry_time)
    );

endmodule

>>> tb/sv/swept_box_collision_time_tb.sv
// Testbench for the swept box collision time block: directed and random box pairs,
// checked in order against a predictor of the slab test. Depends on the RTL and sbct_pkg.
`timescale 1ns / 1ps

class sweep_scoreboard;
    bit          hit_q[$];
    logic [16:0] time_q[$];
    int          errors;
    int          hits;
    int          checked;

    function automatic longint frac_time(longint d, longint s);
        return (d <<< 16) / s;
    endfunction

    function automatic bit overlaps(longint m, longint msz, longint t, longint tsz);
        return !(m + msz <= t || m >= t + tsz);
    endfunction

    function automatic bit narrow(longint m, longint msz, longint t, longint tsz, longint s,
                                  ref longint t_in, ref longint t_out);
        longint mr;
        longint tr;
        longint v;
        mr = m + msz;
        tr = t + tsz;
        if (s < 0) begin
            if (mr <= t) return 0;
            if (tr < m) begin
                v = frac_time(m - tr, -s);
                if (v > t_in) t_in = v;
            end
            v = frac_time(mr - t, -s);
            if (v < t_out) t_out = v;
        end else if (s > 0) begin
            if (m >= tr) return 0;
            if (mr < t) begin
                v = frac_time(t - mr, s);
                if (v > t_in) t_in = v;
            end
            if (tr > m) begin
                v = frac_time(tr - m, s);
                if (v < t_out) t_out = v;
            end
        end
        return t_in <= t_out;
    endfunction

    function void note_pair(longint mx, longint my, longint mw, longint mh, longint tx,
                            longint ty, longint tw, longint th, longint sx, longint sy);
        longint t_in;
        longint t_out;
        bit h;
        t_in = 0;
        t_out = 65536;
        h = 1;
        if (sy == 0 && !overlaps(my, mh, ty, th)) h = 0;
        else if (sx == 0 && !overlaps(mx, mw, tx, tw)) h = 0;
        else if (!narrow(mx, mw, tx, tw, sx, t_in, t_out)) h = 0;
        else if (!narrow(my, mh, ty, th, sy, t_in, t_out)) h = 0;
        hit_q.push_back(h);
        time_q.push_back(h ? 17'(t_in) : 17'h10000);
    endfunction

    function void check_result(bit h, logic [16:0] t);
        bit eh;
        logic [16:0] et;
        if (hit_q.size() == 0) begin
            report_error($sformatf("unexpected result hit=%0d time=%0d", h, t));
            return;
        end
        eh = hit_q.pop_front();
        et = time_q.pop_front();
        checked++;
        hits += eh;
        if (h !== eh) report_error($sformatf("hit %0d, expected %0d", h, eh));
        if (t !== et) report_error($sformatf("entry time %0d, expected %0d", t, et));
    endfunction

    function void report_error(string msg);
        errors++;
        if (errors <= 30) $display("mismatch on word %0d: %s", checked, msg);
    endfunction
endclass

module swept_box_collision_time_tb;
    import sbct_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               o_stall;
    logic signed [15:0] mover_x;
    logic signed [15:0] mover_y;
    logic        [14:0] mover_w;
    logic        [14:0] mover_h;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic        [14:0] target_w;
    logic        [14:0] target_h;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic               o_valid;
    logic               out_stall;
    logic               o_hit;
    logic        [16:0] o_entry_time;

    sweep_scoreboard sb;
    int  idle_cycles;
    int  sent;
    bit  hold_long;
    bit  stim_done;

    swept_box_collision_time u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .o_stall(o_stall),
        .i_mover_x(mover_x), .i_mover_y(mover_y), .i_mover_w(mover_w),
        .i_mover_h(mover_h), .i_target_x(target_x), .i_target_y(target_y),
        .i_target_w(target_w), .i_target_h(target_h), .i_speed_x(speed_x),
        .i_speed_y(speed_y), .o_valid(o_valid), .i_stall(out_stall),
        .o_hit(o_hit), .o_entry_time(o_entry_time)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    task automatic send_pair(logic [15:0] mx, logic [15:0] my, logic [14:0] mw,
                             logic [14:0] mh, logic [15:0] tx, logic [15:0] ty,
                             logic [14:0] tw, logic [14:0] th, logic [15:0] sx,
                             logic [15:0] sy, bit with_gaps);
        int g;
        g = with_gaps ? gap_len() : 0;
        repeat (g) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        mover_x <= mx; mover_y <= my; mover_w <= mw; mover_h <= mh;
        target_x <= tx; target_y <= ty; target_w <= tw; target_h <= th;
        speed_x <= sx; speed_y <= sy;
        @(posedge i_clk iff !o_stall);
        sb.note_pair($signed(mx), $signed(my), mw, mh, $signed(tx), $signed(ty), tw, th,
                     $signed(sx), $signed(sy));
        sent++;
    endtask

    task automatic send_random(bit with_gaps);
        logic [15:0] mx, my, tx, ty, sx, sy;
        logic [14:0] mw, mh, tw, th;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            // Nearby boxes with moderate motion so that hits and partial entries occur.
            tx = 16'($urandom_range(0, 2000) - 1000);
            ty = 16'($urandom_range(0, 2000) - 1000);
            tw = 15'($urandom_range(0, 300));
            th = 15'($urandom_range(0, 300));
            mw = 15'($urandom_range(0, 300));
            mh = 15'($urandom_range(0, 300));
            mx = 16'($signed(tx) + $signed(16'($urandom_range(0, 1600))) - 800);
            my = 16'($signed(ty) + $signed(16'($urandom_range(0, 1600))) - 800);
            sx = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(0, 3000) - 1500);
            sy = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(0, 3000) - 1500);
        end else begin
            mx = 16'($urandom); my = 16'($urandom); tx = 16'($urandom); ty = 16'($urandom);
            mw = 15'($urandom); mh = 15'($urandom); tw = 15'($urandom); th = 15'($urandom);
            sx = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
            sy = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
        end
        send_pair(mx, my, mw, mh, tx, ty, tw, th, sx, sy, with_gaps);
    endtask

    initial begin
        sb = new();
        i_rst_n = 0;
        in_valid = 0;
        mover_x = 0; mover_y = 0; mover_w = 0; mover_h = 0;
        target_x = 0; target_y = 0; target_w = 0; target_h = 0;
        speed_x = 0; speed_y = 0;
        stim_done = 0;
        hold_long = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Resting overlap, resting apart, single-axis motion that misses and hits.
        send_pair(0, 0, 10, 10, 5, 5, 10, 10, 0, 0, 0);
        send_pair(0, 0, 10, 10, 20, 0, 10, 10, 0, 0, 0);
        send_pair(0, 0, 10, 10, 20, 30, 10, 10, 40, 0, 0);
        send_pair(0, 0, 10, 10, 20, 0, 10, 10, 40, 0, 0);
        send_pair(0, 0, 10, 10, 0, 20, 10, 10, 0, 40, 1);
        // Moving away, touching counts as past, entry beyond the step.
        send_pair(30, 0, 10, 10, 0, 0, 10, 10, 5, 0, 0);
        send_pair(10, 0, 10, 10, 0, 0, 10, 10, 5, 0, 0);
        send_pair(-10, 0, 10, 10, 0, 0, 10, 10, -5, 0, 0);
        send_pair(0, 0, 10, 10, 100, 0, 10, 10, 20, 0, 0);
        send_pair(100, 0, 10, 10, 0, 0, 10, 10, -95, 0, 0);
        // Diagonal motion, zero-sized boxes, full-range extremes.
        send_pair(0, 0, 10, 10, 20, 20, 10, 10, 30, 30, 1);
        send_pair(0, 0, 0, 0, 5, 5, 0, 0, 10, 10, 0);
        send_pair(0, 0, 10, 10, 20, 50, 10, 10, 30, 30, 0);
        send_pair(16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 16'h7fff, 16'h7fff,
                  15'h7fff, 15'h7fff, 16'h7fff, 16'h7fff, 0);
        send_pair(16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 16'h8000, 16'h8000,
                  15'h7fff, 15'h7fff, 16'h8000, 16'h8000, 0);
        send_pair(16'h8000, 0, 15'h0, 15'h7fff, 16'h7fff, 0, 15'h0, 15'h7fff,
                  16'h7fff, 0, 0);
        send_pair(16'h7fff, 0, 15'h7fff, 15'h1, 16'h8000, 0, 15'h7fff, 15'h1,
                  16'h8000, 16'hffff, 0);
        send_pair(0, 0, 1, 1, 2, 0, 1, 1, 16'hffff, 1, 0);
        send_pair(0, 0, 3, 3, 10, 0, 3, 3, 7, 16'h8000, 1);
        // The sender waits for the pipeline to drain completely.
        in_valid <= 0;
        while (sb.hit_q.size() != 0) @(posedge i_clk);
        // The receiver holds off while the sender keeps offering words.
        hold_long <= 1;
        repeat (60) send_random(0);
        repeat (1870) send_random($urandom_range(0, 3) == 0);
        in_valid <= 0;
        stim_done = 1;
        while (sb.hit_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.hit_q.size() != 0) sb.report_error("results left over");
        $display("Ran %0d box pairs, %0d results checked, %0d of them hits.",
                 sent, sb.checked, sb.hits);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        int g;
        out_stall = 0;
        @(posedge hold_long);
        out_stall <= 1;
        repeat (80) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 2) == 0) begin
                g = gap_len();
                out_stall <= 1;
                repeat (g) @(posedge i_clk);
            end
            out_stall <= 0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !out_stall) sb.check_result(o_hit, o_entry_time);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_stall) || (o_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial idle_cycles = 0;
endmodule

>>> files.f
rtl/sbct_pkg.sv
rtl/sbct_axis.sv
rtl/sbct_divider.sv
rtl/sbct_resolve.sv
rtl/swept_box_collision_time.sv
tb/sv/swept_box_collision_time_tb.sv
